// File: design/scpu_pkg.sv
// Shared types, constants and coefficient tables for the sine/cosine polynomial unit.
package scpu_pkg;

   localparam int WORK_FRAC = 31;
   localparam int RED_FRAC  = 47;
   localparam int ACC_W     = 34;
   localparam int HORNER_STEPS = 6;

   localparam logic [31:0] TWO_OVER_PI_Q32 = 32'hA2F9836E;
   localparam logic [47:0] HALF_PI_Q47     = 48'hC90FDAA22169;

   // first Horner step that applies for each polynomial length
   localparam logic [2:0] SIN_FIRST_LONG  = 3'd2;
   localparam logic [2:0] SIN_FIRST_SHORT = 3'd4;
   localparam logic [2:0] COS_FIRST_LONG  = 3'd1;
   localparam logic [2:0] COS_FIRST_SHORT = 3'd3;

   localparam logic [1:0] QUADRANT_0 = 2'd0;
   localparam logic [1:0] QUADRANT_1 = 2'd1;
   localparam logic [1:0] QUADRANT_2 = 2'd2;
   localparam logic [1:0] QUADRANT_3 = 2'd3;

   typedef logic signed [ACC_W-1:0] acc_type;

   typedef struct packed {
      logic valid;
      logic long_mode;
      logic neg;
   } tag_type;

   typedef struct packed {
      tag_type     tag;
      logic [1:0]  quad;
      logic        x_neg;
      logic [31:0] x_mag;
      logic [31:0] x2;
   } poly_ctl_type;

   function automatic acc_type cos_coef(input logic [2:0] step);
      acc_type coef;
      case (step)
         3'd1:    coef = -34'sd592;
         3'd2:    coef = 34'sd53261;
         3'd3:    coef = -34'sd2982616;
         3'd4:    coef = 34'sd89478485;
         3'd5:    coef = -34'sd1073741824;
         3'd6:    coef = 34'sd2147483648;
         default: coef = '0;
      endcase
      return coef;
   endfunction

   function automatic acc_type sin_coef(input logic [2:0] step);
      acc_type coef;
      case (step)
         3'd2:    coef = 34'sd5918;
         3'd3:    coef = -34'sd426088;
         3'd4:    coef = 34'sd17895697;
         3'd5:    coef = -34'sd357913941;
         3'd6:    coef = 34'sd2147483648;
         default: coef = '0;
      endcase
      return coef;
   endfunction

   function automatic acc_type sin_init(input logic long_mode);
      return long_mode ? -34'sd54 : -34'sd426088;
   endfunction

   function automatic acc_type cos_init(input logic long_mode);
      return long_mode ? 34'sd4 : 34'sd53261;
   endfunction

   function automatic logic sin_step_on(input logic [2:0] step, input logic long_mode);
      return long_mode ? (step >= SIN_FIRST_LONG) : (step >= SIN_FIRST_SHORT);
   endfunction

   function automatic logic cos_step_on(input logic [2:0] step, input logic long_mode);
      return long_mode ? (step >= COS_FIRST_LONG) : (step >= COS_FIRST_SHORT);
   endfunction

endpackage

// File: design/scpu_reduce.sv
// Quadrant reduction: magnitude, quadrant index, remainder and its square.
module scpu_reduce import scpu_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic               long_mode,
   input  logic signed [31:0] angle,
   output poly_ctl_type       ctl_out
);

   localparam int NW        = 32 - ANGLE_FRAC_BITS;
   localparam int QSHIFT    = ANGLE_FRAC_BITS + 32;
   localparam int RED_SHIFT = RED_FRAC - ANGLE_FRAC_BITS;
   localparam int RND_SHIFT = RED_FRAC - WORK_FRAC;

   tag_type tag1_ff, tag2_ff, tag3_ff, tag4_ff, tag5_ff, tag6_ff, tag7_ff, tag8_ff;
   tag_type tag1_in;

   logic [31:0]        m1_ff, m1_in;
   logic [31:0]        m2_ff;
   logic [63:0]        q_ff, q_in;
   logic [31:0]        m3_ff;
   logic [NW-1:0]      n_ff, n_in;
   logic [63:0]        q_round;
   logic [63:0]        hp_ff, hp_in;
   logic [63:0]        mshift_ff, mshift_in;
   logic [1:0]         quad4_ff, quad5_ff, quad6_ff, quad7_ff, quad8_ff;
   logic signed [63:0] wide_ff, wide_in;
   logic [63:0]        wide_mag, x_round;
   logic [31:0]        x_mag6_ff, x_mag6_in, x_mag7_ff, x_mag8_ff;
   logic               x_neg6_ff, x_neg7_ff, x_neg8_ff;
   logic [63:0]        sq_ff, sq_in;
   logic [31:0]        x2_ff, x2_in;

   always_comb begin
      tag1_in.valid     = in_valid;
      tag1_in.long_mode = long_mode;
      tag1_in.neg       = angle[31];
      m1_in = angle[31] ? (32'd0 - angle) : angle;
      q_in  = 64'(m1_ff) * 64'(TWO_OVER_PI_Q32);
      q_round = q_ff + (64'd1 << (QSHIFT - 1));
      n_in  = NW'(q_round >> QSHIFT);
      hp_in = 64'(n_ff) * 64'(HALF_PI_Q47);
      mshift_in = 64'(m3_ff) << RED_SHIFT;
      wide_in = $signed(mshift_ff) - $signed(hp_ff);
      wide_mag = wide_ff[63] ? 64'(-wide_ff) : 64'(wide_ff);
      x_round = (wide_mag + (64'd1 << (RND_SHIFT - 1))) >> RND_SHIFT;
      x_mag6_in = x_round[31:0];
      sq_in = 64'(x_mag6_ff) * 64'(x_mag6_ff);
      x2_in = 32'((sq_ff + (64'd1 << (WORK_FRAC - 1))) >> WORK_FRAC);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.valid <= 1'b0;
         tag2_ff.valid <= 1'b0;
         tag3_ff.valid <= 1'b0;
         tag4_ff.valid <= 1'b0;
         tag5_ff.valid <= 1'b0;
         tag6_ff.valid <= 1'b0;
         tag7_ff.valid <= 1'b0;
         tag8_ff.valid <= 1'b0;
      end else begin
         tag1_ff <= tag1_in;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
         tag4_ff <= tag3_ff;
         tag5_ff <= tag4_ff;
         tag6_ff <= tag5_ff;
         tag7_ff <= tag6_ff;
         tag8_ff <= tag7_ff;
      end
   end

   always_ff @(posedge clock) begin
      m1_ff     <= m1_in;
      m2_ff     <= m1_ff;
      q_ff      <= q_in;
      m3_ff     <= m2_ff;
      n_ff      <= n_in;
      hp_ff     <= hp_in;
      mshift_ff <= mshift_in;
      quad4_ff  <= n_ff[1:0];
      quad5_ff  <= quad4_ff;
      wide_ff   <= wide_in;
      quad6_ff  <= quad5_ff;
      x_mag6_ff <= x_mag6_in;
      x_neg6_ff <= wide_ff[63];
      quad7_ff  <= quad6_ff;
      x_mag7_ff <= x_mag6_ff;
      x_neg7_ff <= x_neg6_ff;
      sq_ff     <= sq_in;
      quad8_ff  <= quad7_ff;
      x_mag8_ff <= x_mag7_ff;
      x_neg8_ff <= x_neg7_ff;
      x2_ff     <= x2_in;
   end

   always_comb begin
      ctl_out.tag   = tag8_ff;
      ctl_out.quad  = quad8_ff;
      ctl_out.x_neg = x_neg8_ff;
      ctl_out.x_mag = x_mag8_ff;
      ctl_out.x2    = x2_ff;
   end

endmodule

// File: design/scpu_horner_step.sv
// One Horner step for both polynomials: multiply stage, then round and add stage.
module scpu_horner_step import scpu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic [2:0]   step_index,
   input  poly_ctl_type ctl_in,
   input  acc_type      sin_acc_in,
   input  acc_type      cos_acc_in,
   output poly_ctl_type ctl_out,
   output acc_type      sin_acc_out,
   output acc_type      cos_acc_out
);

   poly_ctl_type ctl_a_ff, ctl_b_ff;
   acc_type      sin_acc_a_ff, cos_acc_a_ff;
   acc_type      sin_abs, cos_abs;
   logic [64:0]  sin_prod_in, cos_prod_in, sin_prod_ff, cos_prod_ff;
   logic [64:0]  sin_sum, cos_sum;
   logic [33:0]  sin_rnd, cos_rnd;
   acc_type      sin_new, cos_new;
   acc_type      sin_acc_b_in, cos_acc_b_in, sin_acc_b_ff, cos_acc_b_ff;

   always_comb begin
      sin_abs = sin_acc_in[ACC_W-1] ? -sin_acc_in : sin_acc_in;
      cos_abs = cos_acc_in[ACC_W-1] ? -cos_acc_in : cos_acc_in;
      sin_prod_in = 65'(ctl_in.x2) * 65'(sin_abs[32:0]);
      cos_prod_in = 65'(ctl_in.x2) * 65'(cos_abs[32:0]);
   end

   always_comb begin
      sin_sum = sin_prod_ff + (65'd1 << (WORK_FRAC - 1));
      cos_sum = cos_prod_ff + (65'd1 << (WORK_FRAC - 1));
      sin_rnd = sin_sum[64:WORK_FRAC];
      cos_rnd = cos_sum[64:WORK_FRAC];
      sin_new = sin_acc_a_ff[ACC_W-1] ? sin_coef(step_index) - $signed(sin_rnd)
                                      : sin_coef(step_index) + $signed(sin_rnd);
      cos_new = cos_acc_a_ff[ACC_W-1] ? cos_coef(step_index) - $signed(cos_rnd)
                                      : cos_coef(step_index) + $signed(cos_rnd);
      // pass the accumulator through when its polynomial does not use this step
      sin_acc_b_in = sin_step_on(step_index, ctl_a_ff.tag.long_mode) ? sin_new : sin_acc_a_ff;
      cos_acc_b_in = cos_step_on(step_index, ctl_a_ff.tag.long_mode) ? cos_new : cos_acc_a_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_a_ff.tag.valid <= 1'b0;
         ctl_b_ff.tag.valid <= 1'b0;
      end else begin
         ctl_a_ff <= ctl_in;
         ctl_b_ff <= ctl_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      sin_acc_a_ff <= sin_acc_in;
      cos_acc_a_ff <= cos_acc_in;
      sin_prod_ff  <= sin_prod_in;
      cos_prod_ff  <= cos_prod_in;
      sin_acc_b_ff <= sin_acc_b_in;
      cos_acc_b_ff <= cos_acc_b_in;
   end

   assign ctl_out     = ctl_b_ff;
   assign sin_acc_out = sin_acc_b_ff;
   assign cos_acc_out = cos_acc_b_ff;

endmodule

// File: design/scpu_finish.sv
// Final sine multiply, quadrant mapping, rounding to the result format and clamping.
module scpu_finish import scpu_pkg::*; #(
   parameter int RESULT_FRAC_BITS = 30
) (
   input  logic               clock,
   input  logic               reset,
   input  poly_ctl_type       ctl_in,
   input  acc_type            sin_acc_in,
   input  acc_type            cos_acc_in,
   output logic               out_valid,
   output logic signed [31:0] sine_value,
   output logic signed [31:0] cosine_value
);

   localparam int OUT_SHIFT = WORK_FRAC - RESULT_FRAC_BITS;
   localparam logic [ACC_W-1:0] LIMIT = ACC_W'(1) << RESULT_FRAC_BITS;

   function automatic logic signed [31:0] to_result(input acc_type v);
      logic [ACC_W-1:0] mag;
      logic [ACC_W-1:0] rnd;
      logic [ACC_W-1:0] lim_mag;
      mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
      rnd = (mag + (ACC_W'(1) << (OUT_SHIFT - 1))) >> OUT_SHIFT;
      lim_mag = (rnd > LIMIT) ? LIMIT : rnd;
      return v[ACC_W-1] ? 32'(-lim_mag) : 32'(lim_mag);
   endfunction

   tag_type      tag1_ff, tag2_ff, tag3_ff;
   logic [1:0]   quad1_ff, quad2_ff;
   acc_type      sin_abs;
   logic [64:0]  prod_in, prod_ff;
   logic         prod_neg_ff;
   acc_type      cos1_ff, cos2_ff;
   logic [64:0]  prod_sum;
   logic [33:0]  s_rnd;
   acc_type      s_in, s_ff;
   acc_type      sv_sel, sv_in, cv_in, sv_ff, cv_ff;
   logic         valid_out_ff;
   logic signed [31:0] sine_ff, cosine_ff;

   always_comb begin
      sin_abs = sin_acc_in[ACC_W-1] ? -sin_acc_in : sin_acc_in;
      prod_in = 65'(ctl_in.x_mag) * 65'(sin_abs[32:0]);
      prod_sum = prod_ff + (65'd1 << (WORK_FRAC - 1));
      s_rnd = prod_sum[64:WORK_FRAC];
      s_in = prod_neg_ff ? -$signed(s_rnd) : $signed(s_rnd);
   end

   always_comb begin
      case (quad2_ff)
         QUADRANT_0: begin
            sv_sel = s_ff;
            cv_in  = cos2_ff;
         end
         QUADRANT_1: begin
            sv_sel = cos2_ff;
            cv_in  = -s_ff;
         end
         QUADRANT_2: begin
            sv_sel = -s_ff;
            cv_in  = -cos2_ff;
         end
         default: begin
            sv_sel = -cos2_ff;
            cv_in  = s_ff;
         end
      endcase
      // sine is odd in the angle, cosine even
      sv_in = tag2_ff.neg ? -sv_sel : sv_sel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.valid <= 1'b0;
         tag2_ff.valid <= 1'b0;
         tag3_ff.valid <= 1'b0;
         valid_out_ff  <= 1'b0;
      end else begin
         tag1_ff      <= ctl_in.tag;
         tag2_ff      <= tag1_ff;
         tag3_ff      <= tag2_ff;
         valid_out_ff <= tag3_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      quad1_ff    <= ctl_in.quad;
      prod_ff     <= prod_in;
      prod_neg_ff <= ctl_in.x_neg ^ sin_acc_in[ACC_W-1];
      cos1_ff     <= cos_acc_in;
      quad2_ff    <= quad1_ff;
      s_ff        <= s_in;
      cos2_ff     <= cos1_ff;
      sv_ff       <= sv_in;
      cv_ff       <= cv_in;
      sine_ff     <= to_result(sv_ff);
      cosine_ff   <= to_result(cv_ff);
   end

   assign out_valid    = valid_out_ff;
   assign sine_value   = sine_ff;
   assign cosine_value = cosine_ff;

endmodule

// File: design/sine_cosine_polynomial_unit_core.sv
// Sine/cosine unit: quadrant reduction, Taylor polynomials in Horner form, result mapping.
//
// Input: present an angle on req_angle (signed, ANGLE_FRAC_BITS fraction bits) with start
// high; the transaction is taken at that rising edge. busy is tied low: the pipeline takes
// one angle every cycle with no gaps.
// Output: rsp_valid is high for exactly one cycle per angle, carrying rsp_sine_value and
// rsp_cosine_value (signed, RESULT_FRAC_BITS fraction bits, clamped to +/-1.0). The
// receiver cannot hold results off, and nothing in the block waits on it.
// Pipeline: the reduction (two multipliers, subtract, rounding, squaring), then six Horner
// steps (each a multiply stage, then a round and add stage), then the final multiply,
// quadrant map and clamp.
// Throughput: one transaction per cycle, set by the fully pipelined Horner chain.
// Mode: csr_write_data is written to the polynomial-length register at an edge with
// csr_write_enable high (1 = terms to x^11/x^12, 0 = terms to x^7/x^8); write it only
// while no transaction is in flight.
// Reset: synchronous; drops every transaction in flight and sets the long polynomial mode.
module sine_cosine_polynomial_unit_core import scpu_pkg::*; #(
   parameter int ANGLE_FRAC_BITS  = 24,
   parameter int RESULT_FRAC_BITS = 30
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_angle,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_sine_value,
   output logic signed [31:0] rsp_cosine_value,
   input  logic               csr_write_enable,
   input  logic               csr_write_data
);

   localparam int LATENCY = 24;

   logic         long_polynomial_ff, long_polynomial_in;
   poly_ctl_type step_ctl [0:HORNER_STEPS];
   acc_type      sin_acc [0:HORNER_STEPS];
   acc_type      cos_acc [0:HORNER_STEPS];

   assign busy = 1'b0;

   always_comb begin
      long_polynomial_in = csr_write_enable ? csr_write_data : long_polynomial_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_polynomial_ff <= 1'b1;
      end else begin
         long_polynomial_ff <= long_polynomial_in;
      end
   end

   scpu_reduce #(
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
   ) u_reduce (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .long_mode (long_polynomial_ff),
      .angle     (req_angle),
      .ctl_out   (step_ctl[0])
   );

   assign sin_acc[0] = sin_init(step_ctl[0].tag.long_mode);
   assign cos_acc[0] = cos_init(step_ctl[0].tag.long_mode);

   for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_step
      scpu_horner_step u_step (
         .clock       (clock),
         .reset       (reset),
         .step_index  (3'(k + 1)),
         .ctl_in      (step_ctl[k]),
         .sin_acc_in  (sin_acc[k]),
         .cos_acc_in  (cos_acc[k]),
         .ctl_out     (step_ctl[k+1]),
         .sin_acc_out (sin_acc[k+1]),
         .cos_acc_out (cos_acc[k+1])
      );
   end

   scpu_finish #(
      .RESULT_FRAC_BITS(RESULT_FRAC_BITS)
   ) u_finish (
      .clock        (clock),
      .reset        (reset),
      .ctl_in       (step_ctl[HORNER_STEPS]),
      .sin_acc_in   (sin_acc[HORNER_STEPS]),
      .cos_acc_in   (cos_acc[HORNER_STEPS]),
      .out_valid    (rsp_valid),
      .sine_value   (rsp_sine_value),
      .cosine_value (rsp_cosine_value)
   );

   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without a transaction accepted LATENCY cycles earlier");

   a_flush_on_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   a_sine_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_sine_value) <= $signed(32'(1) << RESULT_FRAC_BITS)) &&
                    ($signed(rsp_sine_value) >= -$signed(32'(1) << RESULT_FRAC_BITS)))
      else $error("sine outside +/-1.0");

   a_cosine_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_cosine_value) <= $signed(32'(1) << RESULT_FRAC_BITS)) &&
                    ($signed(rsp_cosine_value) >= -$signed(32'(1) << RESULT_FRAC_BITS)))
      else $error("cosine outside +/-1.0");

endmodule

// File: tb/sine_cosine_polynomial_unit_core_test.sv
// Testbench for the sine/cosine polynomial unit: a directed table and random angles, checked by a predictor.
module sine_cosine_polynomial_unit_core_test import scpu_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ANGLE_FRAC     = 24;
   localparam int RESULT_FRAC    = 30;
   localparam int PIPE_LATENCY   = 24;
   localparam int MAX_GAP        = 17;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASES         = 6;
   localparam int PHASE_ITEMS    = 275;

   localparam logic [63:0] RECIP_HALF_PI_Q32 = 64'hA2F9836E;
   localparam logic [63:0] HALF_PI_FIXED_Q47 = 64'hC90FDAA22169;
   localparam logic [31:0] UNITY             = 32'h4000_0000;
   localparam logic [31:0] QUARTER_PI        = 32'd13176795;

   typedef struct packed {
      logic [31:0] sine_value;
      logic [31:0] cosine_value;
   } sincos_pair_type;

   typedef struct packed {
      logic [31:0]     angle;
      logic            long_terms;
      logic            typed;
      sincos_pair_type result;
   } table_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_angle = '0;
   logic        rsp_valid;
   logic [31:0] rsp_sine_value;
   logic [31:0] rsp_cosine_value;
   logic        csr_write_enable = 1'b0;
   logic        csr_write_data = 1'b0;

   sincos_pair_type expected_results[$];
   table_row_type   directed_rows[$];
   bit              poly_long = 1'b1;
   bit              typed_pending = 1'b0;
   sincos_pair_type typed_result = '0;
   int              errors = 0;
   int              idle_cycles = 0;

   sine_cosine_polynomial_unit_core DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_angle        (req_angle),
      .rsp_valid        (rsp_valid),
      .rsp_sine_value   (rsp_sine_value),
      .rsp_cosine_value (rsp_cosine_value),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic logic [63:0] magnitude(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   // shift right, rounding halves away from zero
   function automatic longint round_away(input longint v, input int sh);
      logic [63:0] m;
      m = (magnitude(v) + (64'd1 << (sh - 1))) >> sh;
      return (v < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint mul_q31(input longint a, input longint b);
      logic [63:0] p;
      logic [63:0] m;
      p = magnitude(a) * magnitude(b);
      m = (p + (64'd1 << 30)) >> 31;
      return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
   endfunction

   // Taylor coefficient of x2^j, Q.31
   function automatic longint taylor_coef(input bit cosine, input int j);
      if (cosine) begin
         case (j)
            0:       return 64'sd2147483648;
            1:       return -64'sd1073741824;
            2:       return 64'sd89478485;
            3:       return -64'sd2982616;
            4:       return 64'sd53261;
            5:       return -64'sd592;
            default: return 64'sd4;
         endcase
      end else begin
         case (j)
            0:       return 64'sd2147483648;
            1:       return -64'sd357913941;
            2:       return 64'sd17895697;
            3:       return -64'sd426088;
            4:       return 64'sd5918;
            default: return -64'sd54;
         endcase
      end
   endfunction

   function automatic longint horner_sum(input bit cosine, input int top, input longint x2);
      longint acc;
      acc = taylor_coef(cosine, top);
      for (int j = top - 1; j >= 0; j--)
         acc = taylor_coef(cosine, j) + mul_q31(x2, acc);
      return acc;
   endfunction

   function automatic logic [31:0] scale_to_result(input longint v);
      longint r;
      r = round_away(v, 31 - RESULT_FRAC);
      if (r > (64'sd1 <<< RESULT_FRAC))
         r = 64'sd1 <<< RESULT_FRAC;
      if (r < -(64'sd1 <<< RESULT_FRAC))
         r = -(64'sd1 <<< RESULT_FRAC);
      return r[31:0];
   endfunction

   function automatic sincos_pair_type predict_sincos(input logic [31:0] angle,
                                                      input bit long_terms);
      bit              neg;
      logic [63:0]     mag;
      logic [63:0]     quot;
      logic [63:0]     quadrant;
      longint          wide;
      longint          x;
      longint          x2;
      longint          s;
      longint          c;
      longint          sv;
      longint          cv;
      sincos_pair_type res;
      neg = angle[31];
      mag = neg ? (64'h1_0000_0000 - {32'd0, angle}) : {32'd0, angle};
      quot = mag * RECIP_HALF_PI_Q32;
      quadrant = (quot + (64'd1 << (ANGLE_FRAC + 31))) >> (ANGLE_FRAC + 32);
      wide = longint'(mag << (47 - ANGLE_FRAC)) - longint'(quadrant * HALF_PI_FIXED_Q47);
      x = round_away(wide, 16);
      x2 = mul_q31(x, x);
      s = mul_q31(x, horner_sum(1'b0, long_terms ? 5 : 3, x2));
      c = horner_sum(1'b1, long_terms ? 6 : 4, x2);
      case (quadrant[1:0])
         QUADRANT_0: begin sv = s;  cv = c;  end
         QUADRANT_1: begin sv = c;  cv = -s; end
         QUADRANT_2: begin sv = -s; cv = -c; end
         default:    begin sv = -c; cv = s;  end
      endcase
      if (neg)
         sv = -sv;
      res.sine_value = scale_to_result(sv);
      res.cosine_value = scale_to_result(cv);
      return res;
   endfunction

   function automatic void add_row(input logic [31:0] angle, input bit long_terms,
                                   input bit typed, input sincos_pair_type result);
      table_row_type row;
      row.angle = angle;
      row.long_terms = long_terms;
      row.typed = typed;
      row.result = result;
      directed_rows.push_back(row);
   endfunction

   function automatic logic [31:0] random_angle();
      logic [31:0] a;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: a = $urandom;
         4, 5:       a = $urandom_range(0, 32'h0FFF_FFFF) - 32'h0800_0000;
         6, 7: begin
            // land near a multiple of pi/4, where the quadrant rounding flips
            a = $urandom_range(0, 162) * QUARTER_PI + $urandom_range(0, 64) - 32'd32;
            if ($urandom_range(0, 1))
               a = -a;
         end
         8:          a = $urandom_range(0, 511) - 32'd256;
         default: begin
            case ($urandom_range(0, 5))
               0:       a = 32'h0000_0000;
               1:       a = 32'h0000_0001;
               2:       a = 32'hFFFF_FFFF;
               3:       a = 32'h7FFF_FFFF;
               4:       a = 32'h8000_0000;
               default: a = 32'h8000_0001;
            endcase
         end
      endcase
      return a;
   endfunction

   // hold off the sender until every transaction in flight has returned
   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (expected_results.size() != 0)
         @(negedge clock);
   endtask

   task automatic set_polynomial(input bit long_terms);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data <= long_terms;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_angle(input logic [31:0] angle, input int gap,
                             input bit typed, input sincos_pair_type result);
      @(negedge clock);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      typed_pending = typed;
      typed_result = result;
      start <= 1'b1;
      req_angle <= angle;
      do
         @(posedge clock);
      while (busy !== 1'b0);
   endtask

   always @(posedge clock) begin : check_results
      sincos_pair_type want;
      if (reset) begin
         poly_long = 1'b1;
         expected_results.delete();
      end else begin
         if (csr_write_enable)
            poly_long = csr_write_data;
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               $error("result with no transaction pending: sine %0d cosine %0d",
                      $signed(rsp_sine_value), $signed(rsp_cosine_value));
               errors++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_sine_value !== want.sine_value) begin
                  $error("sine_value: expected %0d, actual %0d",
                         $signed(want.sine_value), $signed(rsp_sine_value));
                  errors++;
               end
               if (rsp_cosine_value !== want.cosine_value) begin
                  $error("cosine_value: expected %0d, actual %0d",
                         $signed(want.cosine_value), $signed(rsp_cosine_value));
                  errors++;
               end
            end
         end
         if (start && !busy)
            expected_results.push_back(typed_pending ? typed_result
                                                     : predict_sincos(req_angle, poly_long));
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin : stimulus
      bit calm;
      calm = 1'b0;

      add_row(32'h0000_0000, 1'b1, 1'b1, '{32'h0, UNITY});
      add_row(32'h0000_0001, 1'b1, 1'b0, '0);
      add_row(32'hFFFF_FFFF, 1'b1, 1'b0, '0);
      add_row(32'h7FFF_FFFF, 1'b1, 1'b0, '0);
      add_row(32'h8000_0000, 1'b1, 1'b0, '0);
      add_row(32'h8000_0001, 1'b1, 1'b0, '0);
      add_row(QUARTER_PI - 1, 1'b1, 1'b0, '0);
      add_row(QUARTER_PI, 1'b1, 1'b0, '0);
      add_row(32'd26353589, 1'b1, 1'b0, '0);
      add_row(32'd52707179, 1'b1, 1'b0, '0);
      add_row(32'd79060767, 1'b1, 1'b0, '0);
      add_row(32'd105414357, 1'b1, 1'b0, '0);
      add_row(-32'd26353589, 1'b1, 1'b0, '0);
      add_row(-32'd79060767, 1'b1, 1'b0, '0);
      add_row(32'h5555_5555, 1'b1, 1'b0, '0);
      add_row(32'hAAAA_AAAA, 1'b1, 1'b0, '0);
      add_row(32'h00FF_FFFF, 1'b1, 1'b0, '0);
      add_row(32'h0000_0000, 1'b0, 1'b1, '{32'h0, UNITY});
      add_row(QUARTER_PI, 1'b0, 1'b0, '0);
      add_row(32'h7FFF_FFFF, 1'b0, 1'b0, '0);
      add_row(32'h8000_0000, 1'b0, 1'b0, '0);
      add_row(-32'd52707179, 1'b0, 1'b0, '0);
      add_row(32'h0100_0000, 1'b0, 1'b0, '0);
      add_row(32'hFF00_0000, 1'b0, 1'b0, '0);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].long_terms != poly_long)
            set_polynomial(directed_rows[i].long_terms);
         send_angle(directed_rows[i].angle, $urandom_range(0, MAX_GAP),
                    directed_rows[i].typed, directed_rows[i].result);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         set_polynomial(phase % 2 == 0);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // toggle between back-to-back stretches and random gaps
            if ($urandom_range(0, 39) == 0)
               calm = !calm;
            if (k == PHASE_ITEMS / 2)
               drain_results();
            send_angle(random_angle(), calm ? 0 : $urandom_range(0, MAX_GAP), 1'b0, '0);
         end
      end

      drain_results();
      repeat (PIPE_LATENCY + 8) @(posedge clock);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
